// ===== hdl/stereo_feedback_delay_macros.svh =====
// Assertion macros for the stereo feedback delay.
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle.
`define SFD_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stereo feedback delay: check failed");

// Check that a condition implies another in the next cycle.
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stereo feedback delay: check failed");

`else

`define SFD_ASSERT_IMPLIES(lbl, ante, cons)
`define SFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/sfd_pkg.sv =====
// Types, constants and saturation helper for the stereo feedback delay.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELAY_LEFT  = 8'd0,
        CFG_DELAY_RIGHT = 8'd1,
        CFG_FEEDBACK    = 8'd2,
        CFG_MIX         = 8'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [14:0] DELAY_RESET    = 15'd12000;
    localparam logic [14:0] FEEDBACK_RESET = 15'd9830;
    localparam logic [15:0] MIX_RESET      = 16'd16384;

    // Gain limits in Q1.15
    localparam logic [14:0] FB_MAX  = 15'd31130;
    localparam logic [16:0] MIX_ONE = 17'd32768;

    typedef logic signed [23:0] sample_t;

    // Saturate a wide signed value to a Q1.23 sample.
    function automatic sample_t sat24(input logic signed [41:0] x);
        logic signed [41:0] hi;
        logic signed [41:0] lo;
        hi = 42'sd8388607;
        lo = -42'sd8388608;
        if (x > hi) begin
            sat24 = 24'sh7FFFFF;
        end else if (x < lo) begin
            sat24 = 24'sh800000;
        end else begin
            sat24 = x[23:0];
        end
    endfunction

endpackage

// ===== hdl/stereo_feedback_delay.sv =====
// Polyphonic stereo feedback delay with wet/dry mix, top level.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_valid / s_ready  | voice, samples, right_connected, offsets
//  m_      | out       | m_valid / m_ready  | out_voice, left_out, right_out
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One request enters per cycle while s_ready is high; its result passes the input register,
// the ring read register and the result register in that order before it leaves.
// The ring read is issued from the input stage and the write-back happens in the
// second stage; a same-address write/read pair is bypassed from the write-data register.
// Rings are not swept after reset: a per-voice fill pointer and wrap flag mark
// unwritten entries, which read as zero, so requests are taken from the first cycle.
// A stalled result register holds both stages behind it; s_ready drops only when all
// three stages are full and m_ready is low.
`timescale 1ns / 1ps
`include "stereo_feedback_delay_macros.svh"

module stereo_feedback_delay #(
    parameter int DEPTH  = 32768,
    parameter int VOICES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [3:0]                      s_voice,
    input  logic signed [23:0]              s_left_sample,
    input  logic signed [23:0]              s_right_sample,
    input  logic                            s_right_connected,
    input  logic signed [15:0]              s_delay_left_offset,
    input  logic signed [15:0]              s_delay_right_offset,
    input  logic signed [15:0]              s_feedback_offset,
    input  logic signed [15:0]              s_mix_offset,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [3:0]                      m_out_voice,
    output logic signed [23:0]              m_left_out,
    output logic signed [23:0]              m_right_out,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import sfd_pkg::*;

    localparam int AW        = $clog2(DEPTH);
    localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MEM_WORDS = VOICES << AW;

    localparam logic signed [18:0] DLY_MAX = 19'(DEPTH - 1);
    localparam logic [AW-1:0]      IDX_TOP = AW'(DEPTH - 1);
    localparam logic [AW:0]        IDX_WRAP = (AW + 1)'(DEPTH);
    localparam logic [4:0]         VOICE_LIMIT = 5'(VOICES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [14:0] base_delay_left_reg;
    logic [14:0] base_delay_right_reg;
    logic [14:0] base_feedback_reg;
    logic [15:0] base_mix_reg;

    assign cfg_ready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_delay_left_reg  <= DELAY_RESET;
            base_delay_right_reg <= DELAY_RESET;
            base_feedback_reg    <= FEEDBACK_RESET;
            base_mix_reg         <= MIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DELAY_LEFT:  base_delay_left_reg  <= cfg_data[14:0];
                CFG_DELAY_RIGHT: base_delay_right_reg <= cfg_data[14:0];
                CFG_FEEDBACK:    base_feedback_reg    <= cfg_data[14:0];
                CFG_MIX:         base_mix_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;
    logic s2_fire;
    logic s1_adv;
    logic s_take;

    assign s2_fire = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s1_adv  = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_take  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [3:0]         s1_voice_reg;
    sample_t            s1_lin_reg;
    sample_t            s1_rin_reg;
    logic               s1_rconn_reg;
    logic signed [15:0] s1_dl_off_reg;
    logic signed [15:0] s1_dr_off_reg;
    logic signed [15:0] s1_fb_off_reg;
    logic signed [15:0] s1_mix_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            s1_voice_reg   <= s_voice;
            s1_lin_reg     <= s_left_sample;
            s1_rin_reg     <= s_right_sample;
            s1_rconn_reg   <= s_right_connected;
            s1_dl_off_reg  <= s_delay_left_offset;
            s1_dr_off_reg  <= s_delay_right_offset;
            s1_fb_off_reg  <= s_feedback_offset;
            s1_mix_off_reg <= s_mix_offset;
        end
    end

    // Per-voice write pointers and wrap flags
    logic [AW-1:0]     wp_reg [VOICES];
    logic [VOICES-1:0] wrap_reg;

    logic [VW-1:0]      s1_vidx;
    logic               s1_in_range;
    logic [AW-1:0]      s1_wp;
    logic               s1_wrapped;
    logic signed [18:0] sum_dl;
    logic signed [18:0] sum_dr;
    logic [AW-1:0]      dly_l;
    logic [AW-1:0]      dly_r;
    logic [AW:0]        diff_l;
    logic [AW:0]        diff_r;
    logic [AW:0]        diff_l_wrap;
    logic [AW:0]        diff_r_wrap;
    logic [AW-1:0]      rd_idx_l;
    logic [AW-1:0]      rd_idx_r;
    logic signed [16:0] sum_fb;
    logic [14:0]        fb_clamped;
    logic signed [17:0] sum_mix;
    logic [15:0]        mix_clamped;
    sample_t            s1_rin_sel;
    logic               fwd_l;
    logic               fwd_r;

    assign s1_vidx     = s1_voice_reg[VW-1:0];
    assign s1_in_range = {1'b0, s1_voice_reg} < VOICE_LIMIT;
    assign s1_wp       = s1_in_range ? wp_reg[s1_vidx] : '0;
    assign s1_wrapped  = s1_in_range ? wrap_reg[s1_vidx] : 1'b0;
    assign s1_rin_sel  = s1_rconn_reg ? s1_rin_reg : s1_lin_reg;

    // Clamp delays to 1..DEPTH-1
    always_comb begin
        sum_dl = $signed({4'b0000, base_delay_left_reg})
               + {{3{s1_dl_off_reg[15]}}, s1_dl_off_reg};
        sum_dr = $signed({4'b0000, base_delay_right_reg})
               + {{3{s1_dr_off_reg[15]}}, s1_dr_off_reg};
        if (sum_dl < 19'sd1) begin
            dly_l = AW'(1);
        end else if (sum_dl > DLY_MAX) begin
            dly_l = IDX_TOP;
        end else begin
            dly_l = sum_dl[AW-1:0];
        end
        if (sum_dr < 19'sd1) begin
            dly_r = AW'(1);
        end else if (sum_dr > DLY_MAX) begin
            dly_r = IDX_TOP;
        end else begin
            dly_r = sum_dr[AW-1:0];
        end
    end

    // Read index = write pointer - delay, modulo DEPTH
    always_comb begin
        diff_l      = {1'b0, s1_wp} - {1'b0, dly_l};
        diff_r      = {1'b0, s1_wp} - {1'b0, dly_r};
        diff_l_wrap = diff_l + IDX_WRAP;
        diff_r_wrap = diff_r + IDX_WRAP;
        rd_idx_l    = diff_l[AW] ? diff_l_wrap[AW-1:0] : diff_l[AW-1:0];
        rd_idx_r    = diff_r[AW] ? diff_r_wrap[AW-1:0] : diff_r[AW-1:0];
    end

    // Clamp feedback to 0..FB_MAX and mix to 0..1.0
    always_comb begin
        sum_fb  = $signed({2'b00, base_feedback_reg}) + {s1_fb_off_reg[15], s1_fb_off_reg};
        sum_mix = $signed({2'b00, base_mix_reg}) + {{2{s1_mix_off_reg[15]}}, s1_mix_off_reg};
        if (sum_fb < 17'sd0) begin
            fb_clamped = '0;
        end else if (sum_fb > $signed({2'b00, FB_MAX})) begin
            fb_clamped = FB_MAX;
        end else begin
            fb_clamped = sum_fb[14:0];
        end
        if (sum_mix < 18'sd0) begin
            mix_clamped = '0;
        end else if (sum_mix > $signed({1'b0, MIX_ONE})) begin
            mix_clamped = MIX_ONE[15:0];
        end else begin
            mix_clamped = sum_mix[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 registers
    // ------------------------------------------------------------------
    logic [3:0]    s2_voice_reg;
    logic          s2_in_range_reg;
    sample_t       s2_lin_reg;
    sample_t       s2_rin_reg;
    logic [AW-1:0] s2_wp_reg;
    logic [14:0]   s2_fb_reg;
    logic [15:0]   s2_mix_reg;
    logic          s2_vld_l_reg;
    logic          s2_vld_r_reg;
    logic          s2_fwd_l_reg;
    logic          s2_fwd_r_reg;
    sample_t       left_q_reg;
    sample_t       right_q_reg;
    sample_t       last_l_reg;
    sample_t       last_r_reg;

    // Bypass when the item leaving stage 2 writes the address being read
    assign fwd_l = s2_fire && s2_in_range_reg && (s2_voice_reg == s1_voice_reg)
                && (s2_wp_reg == rd_idx_l);
    assign fwd_r = s2_fire && s2_in_range_reg && (s2_voice_reg == s1_voice_reg)
                && (s2_wp_reg == rd_idx_r);

    // Advance write pointer, set wrap flag on rollover
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICES; i++) begin
                wp_reg[i] <= '0;
            end
            wrap_reg <= '0;
        end else if (s1_adv && s1_in_range) begin
            if (s1_wp == IDX_TOP) begin
                wp_reg[s1_vidx]   <= '0;
                wrap_reg[s1_vidx] <= 1'b1;
            end else begin
                wp_reg[s1_vidx] <= s1_wp + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (!s2_valid_reg || s2_fire) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Move the stage 1 item forward
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_voice_reg    <= s1_voice_reg;
            s2_in_range_reg <= s1_in_range;
            s2_lin_reg      <= s1_lin_reg;
            s2_rin_reg      <= s1_rin_sel;
            s2_wp_reg       <= s1_wp;
            s2_fb_reg       <= fb_clamped;
            s2_mix_reg      <= mix_clamped;
            s2_vld_l_reg    <= s1_wrapped || (rd_idx_l < s1_wp);
            s2_vld_r_reg    <= s1_wrapped || (rd_idx_r < s1_wp);
            s2_fwd_l_reg    <= fwd_l;
            s2_fwd_r_reg    <= fwd_r;
        end
    end

    // ------------------------------------------------------------------
    // Ring memories
    // ------------------------------------------------------------------
    sample_t left_mem  [MEM_WORDS];
    sample_t right_mem [MEM_WORDS];

    logic [VW+AW-1:0] rd_addr_l;
    logic [VW+AW-1:0] rd_addr_r;
    logic [VW+AW-1:0] wr_addr;
    logic             mem_we;
    sample_t          store_l;
    sample_t          store_r;

    assign rd_addr_l = {s1_vidx, rd_idx_l};
    assign rd_addr_r = {s1_vidx, rd_idx_r};
    assign wr_addr   = {s2_voice_reg[VW-1:0], s2_wp_reg};
    assign mem_we    = s2_fire && s2_in_range_reg;

    // Read the delayed samples
    always_ff @(posedge aclk) begin
        if (s1_adv && s1_in_range) begin
            left_q_reg  <= left_mem[rd_addr_l];
            right_q_reg <= right_mem[rd_addr_r];
        end
    end

    // Write back input plus feedback
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            left_mem[wr_addr]  <= store_l;
            right_mem[wr_addr] <= store_r;
        end
    end

    // Hold the last written samples for the bypass
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            last_l_reg <= store_l;
            last_r_reg <= store_r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: feedback and mix arithmetic
    // ------------------------------------------------------------------
    sample_t            ldel;
    sample_t            rdel;
    logic signed [16:0] wet_gain;
    logic signed [16:0] dry_gain;
    logic signed [39:0] fb_prod_l;
    logic signed [39:0] fb_prod_r;
    logic signed [39:0] fb_rnd_l;
    logic signed [39:0] fb_rnd_r;
    logic signed [41:0] store_sum_l;
    logic signed [41:0] store_sum_r;
    logic signed [40:0] dry_prod_l;
    logic signed [40:0] dry_prod_r;
    logic signed [40:0] wet_prod_l;
    logic signed [40:0] wet_prod_r;
    logic signed [41:0] mix_sum_l;
    logic signed [41:0] mix_sum_r;
    logic signed [41:0] mix_rnd_l;
    logic signed [41:0] mix_rnd_r;

    // Pick bypass, stored sample or zero for an unwritten entry
    always_comb begin
        if (s2_fwd_l_reg) begin
            ldel = last_l_reg;
        end else if (s2_vld_l_reg) begin
            ldel = left_q_reg;
        end else begin
            ldel = '0;
        end
        if (s2_fwd_r_reg) begin
            rdel = last_r_reg;
        end else if (s2_vld_r_reg) begin
            rdel = right_q_reg;
        end else begin
            rdel = '0;
        end
    end

    // Stored sample: input + round(delayed * feedback)
    always_comb begin
        fb_prod_l   = ldel * $signed({1'b0, s2_fb_reg});
        fb_prod_r   = rdel * $signed({1'b0, s2_fb_reg});
        fb_rnd_l    = (fb_prod_l + 40'sd16384) >>> 15;
        fb_rnd_r    = (fb_prod_r + 40'sd16384) >>> 15;
        store_sum_l = 42'(s2_lin_reg) + 42'(fb_rnd_l);
        store_sum_r = 42'(s2_rin_reg) + 42'(fb_rnd_r);
        store_l     = sat24(store_sum_l);
        store_r     = sat24(store_sum_r);
    end

    // Output: round(dry * (1 - mix) + delayed * mix)
    always_comb begin
        wet_gain   = $signed({1'b0, s2_mix_reg});
        dry_gain   = $signed(MIX_ONE - {1'b0, s2_mix_reg});
        dry_prod_l = s2_lin_reg * dry_gain;
        dry_prod_r = s2_rin_reg * dry_gain;
        wet_prod_l = ldel * wet_gain;
        wet_prod_r = rdel * wet_gain;
        mix_sum_l  = 42'(dry_prod_l) + 42'(wet_prod_l);
        mix_sum_r  = 42'(dry_prod_r) + 42'(wet_prod_r);
        mix_rnd_l  = (mix_sum_l + 42'sd16384) >>> 15;
        mix_rnd_r  = (mix_sum_r + 42'sd16384) >>> 15;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [3:0] m_voice_reg;
    sample_t    m_left_reg;
    sample_t    m_right_reg;
    logic       m_voice_unknown;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the blend, zero for an unknown voice
    always_ff @(posedge aclk) begin
        if (s2_fire) begin
            m_voice_reg <= s2_voice_reg;
            m_left_reg  <= s2_in_range_reg ? sat24(mix_rnd_l) : '0;
            m_right_reg <= s2_in_range_reg ? sat24(mix_rnd_r) : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_voice = m_voice_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

    assign m_voice_unknown = {1'b0, m_voice_reg} >= VOICE_LIMIT;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SFD_ASSERT_IMPLIES(a_bypass_has_item, fwd_l || fwd_r, mem_we)
    `SFD_ASSERT_IMPLIES(a_stall_only_full, !s_ready, s1_valid_reg && s2_valid_reg && m_valid_reg)
    `SFD_ASSERT_IMPLIES(a_result_from_s2, $rose(m_valid), $past(s2_valid_reg))
    `SFD_ASSERT_IMPLIES(a_unknown_voice_zero, m_valid && m_voice_unknown, m_left_out == 24'sd0 && m_right_out == 24'sd0)
    `SFD_ASSERT_NEXT(a_write_advances, mem_we && !s1_adv, s2_valid_reg == s1_valid_reg || !s2_valid_reg)

endmodule

// ===== tb/stereo_feedback_delay_tb.sv =====
// Self-checking testbench for the stereo feedback delay with a predicting scoreboard.
`timescale 1ns / 1ps

module stereo_feedback_delay_tb;
    import sfd_pkg::*;

    localparam int     RING_DEPTH     = 32768;
    localparam int     NUM_VOICES     = 16;
    localparam longint S24_MAX        = 8388607;
    localparam longint S24_MIN        = -8388608;
    localparam int     DRAIN_CYCLES   = 12;
    localparam int     RANDOM_PHASES  = 6;
    localparam int     PHASE_REQUESTS = 290;
    localparam int     MAX_REPORTS    = 100;

    localparam sample_t            PEAK_POS  = 24'sh7FFFFF;
    localparam sample_t            PEAK_NEG  = 24'sh800000;
    localparam logic signed [15:0] OFS_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] OFS_MIN   = 16'sh8000;
    localparam logic [3:0]         TOP_VOICE = 4'hF;

    // Highest index on the register bus; everything above CFG_MIX is unused
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_TOP = '1;

    typedef struct {
        logic [3:0]         voice;
        sample_t            left_in;
        sample_t            right_in;
        logic               right_connected;
        logic signed [15:0] delay_left_ofs;
        logic signed [15:0] delay_right_ofs;
        logic signed [15:0] feedback_ofs;
        logic signed [15:0] mix_ofs;
    } echo_request_t;

    typedef struct {
        logic [3:0] voice;
        sample_t    left_out;
        sample_t    right_out;
    } echo_result_t;

    // Mirror of the delay rings and registers; predicts each blended output.
    class echo_scoreboard;
        int unsigned  base_delay_left;
        int unsigned  base_delay_right;
        int unsigned  base_feedback;
        int unsigned  base_mix;
        int           left_ring  [NUM_VOICES*RING_DEPTH];
        int           right_ring [NUM_VOICES*RING_DEPTH];
        int unsigned  write_ptr  [NUM_VOICES];
        echo_result_t expected_echoes[$];
        int           failures;

        function new();
            base_delay_left  = DELAY_RESET;
            base_delay_right = DELAY_RESET;
            base_feedback    = FEEDBACK_RESET;
            base_mix         = MIX_RESET;
            failures         = 0;
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        // Divide by 32768, rounding half up.
        function longint round_q15(longint x);
            return (x + 16384) >>> 15;
        endfunction

        // Track a register write; drop unused indexes.
        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DELAY_LEFT:  base_delay_left  = data[14:0];
                CFG_DELAY_RIGHT: base_delay_right = data[14:0];
                CFG_FEEDBACK:    base_feedback    = data[14:0];
                CFG_MIX:         base_mix         = data;
                default: ;
            endcase
        endfunction

        function echo_result_t predict_echo(echo_request_t r);
            echo_result_t o;
            longint       lin, rin, dl, dr, fb, mix, ldel, rdel;
            int           base, wp;
            o.voice     = r.voice;
            o.left_out  = '0;
            o.right_out = '0;
            if (int'(r.voice) >= NUM_VOICES) return o;
            lin = r.left_in;
            rin = r.right_connected ? r.right_in : r.left_in;

            // Add offsets, then clamp delay and gains
            dl  = clip(longint'(base_delay_left) + longint'(r.delay_left_ofs), 1, RING_DEPTH - 1);
            dr  = clip(longint'(base_delay_right) + longint'(r.delay_right_ofs), 1,
                       RING_DEPTH - 1);
            fb  = clip(longint'(base_feedback) + longint'(r.feedback_ofs), 0, longint'(FB_MAX));
            mix = clip(longint'(base_mix) + longint'(r.mix_ofs), 0, longint'(MIX_ONE));

            // Read behind the write pointer, then write back input plus feedback
            wp = int'(write_ptr[r.voice]);
            if (wp >= RING_DEPTH) wp = 0;
            base = int'(r.voice) * RING_DEPTH;
            ldel = left_ring[base + (wp + RING_DEPTH - int'(dl)) % RING_DEPTH];
            rdel = right_ring[base + (wp + RING_DEPTH - int'(dr)) % RING_DEPTH];
            left_ring[base + wp]  = int'(clip(lin + round_q15(ldel * fb), S24_MIN, S24_MAX));
            right_ring[base + wp] = int'(clip(rin + round_q15(rdel * fb), S24_MIN, S24_MAX));
            write_ptr[r.voice] = (wp + 1) % RING_DEPTH;

            // Blend dry and wet
            o.left_out  = sample_t'(clip(round_q15(lin * (longint'(MIX_ONE) - mix) + ldel * mix),
                                         S24_MIN, S24_MAX));
            o.right_out = sample_t'(clip(round_q15(rin * (longint'(MIX_ONE) - mix) + rdel * mix),
                                         S24_MIN, S24_MAX));
            return o;
        endfunction

        function void note_request(echo_request_t r);
            expected_echoes.push_back(predict_echo(r));
        endfunction

        function int pending();
            return expected_echoes.size();
        endfunction

        function void flag(string field, logic signed [23:0] want, logic signed [23:0] got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(echo_result_t got);
            echo_result_t want;
            if (expected_echoes.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result voice %0d left %0d right %0d",
                             $time, got.voice, got.left_out, got.right_out);
                return;
            end
            want = expected_echoes.pop_front();
            if (got.voice !== want.voice)         flag("out_voice", want.voice, got.voice);
            if (got.left_out !== want.left_out)   flag("left_out", want.left_out, got.left_out);
            if (got.right_out !== want.right_out) flag("right_out", want.right_out, got.right_out);
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid              = 1'b0;
    logic                    s_ready;
    logic [3:0]              s_voice              = '0;
    logic signed [23:0]      s_left_sample        = '0;
    logic signed [23:0]      s_right_sample       = '0;
    logic                    s_right_connected    = 1'b0;
    logic signed [15:0]      s_delay_left_offset  = '0;
    logic signed [15:0]      s_delay_right_offset = '0;
    logic signed [15:0]      s_feedback_offset    = '0;
    logic signed [15:0]      s_mix_offset         = '0;

    logic                    m_valid;
    logic                    m_ready              = 1'b0;
    logic [3:0]              m_out_voice;
    logic signed [23:0]      m_left_out;
    logic signed [23:0]      m_right_out;

    logic                    cfg_valid            = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index            = '0;
    logic [CFG_DATA_W-1:0]   cfg_data             = '0;

    echo_scoreboard sb;
    echo_request_t  taken_request;
    echo_result_t   seen_echo;
    logic [9:0]     stall_tick   = '0;
    int             burst_left   = 0;
    bit             quiet_sender = 1'b0;

    stereo_feedback_delay #(
        .DEPTH  (RING_DEPTH),
        .VOICES (NUM_VOICES)
    ) DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_voice              (s_voice),
        .s_left_sample        (s_left_sample),
        .s_right_sample       (s_right_sample),
        .s_right_connected    (s_right_connected),
        .s_delay_left_offset  (s_delay_left_offset),
        .s_delay_right_offset (s_delay_right_offset),
        .s_feedback_offset    (s_feedback_offset),
        .s_mix_offset         (s_mix_offset),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_out_voice          (m_out_voice),
        .m_left_out           (m_left_out),
        .m_right_out          (m_right_out),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Stall the result channel: all ready, mostly ready, mostly stalled, toggling
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= stall_tick[2];
        endcase
    end

    // Track register writes
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready)
            sb.write_register(cfg_index, cfg_data);
    end

    // Predict each accepted request
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            taken_request.voice           = s_voice;
            taken_request.left_in         = s_left_sample;
            taken_request.right_in        = s_right_sample;
            taken_request.right_connected = s_right_connected;
            taken_request.delay_left_ofs  = s_delay_left_offset;
            taken_request.delay_right_ofs = s_delay_right_offset;
            taken_request.feedback_ofs    = s_feedback_offset;
            taken_request.mix_ofs         = s_mix_offset;
            sb.note_request(taken_request);
        end
    end

    // Check each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_echo.voice     = m_out_voice;
            seen_echo.left_out  = m_left_out;
            seen_echo.right_out = m_right_out;
            sb.check_result(seen_echo);
        end
    end

    function automatic echo_request_t make_request(logic [3:0] v, sample_t l, sample_t r,
                                                   logic rc, logic signed [15:0] dlo,
                                                   logic signed [15:0] dro,
                                                   logic signed [15:0] fbo,
                                                   logic signed [15:0] mxo);
        echo_request_t q;
        q.voice           = v;
        q.left_in         = l;
        q.right_in        = r;
        q.right_connected = rc;
        q.delay_left_ofs  = dlo;
        q.delay_right_ofs = dro;
        q.feedback_ofs    = fbo;
        q.mix_ofs         = mxo;
        return q;
    endfunction

    function automatic sample_t random_level();
        case ($urandom_range(0, 9))
            0:       return PEAK_POS;
            1:       return PEAK_NEG;
            2, 3, 4: return sample_t'(int'($urandom_range(0, 4000)) - 2000);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Mostly small offsets around the base value, sometimes any 16-bit value
    function automatic logic signed [15:0] random_offset(int span);
        if ($urandom_range(0, 4) == 0) return 16'($urandom());
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic echo_request_t random_request();
        echo_request_t q;
        q.voice           = 4'($urandom_range(0, NUM_VOICES - 1));
        q.left_in         = random_level();
        q.right_in        = random_level();
        q.right_connected = ($urandom_range(0, 3) != 0);
        q.delay_left_ofs  = random_offset(6);
        q.delay_right_ofs = random_offset(6);
        q.feedback_ofs    = random_offset(4000);
        q.mix_ofs         = random_offset(8000);
        return q;
    endfunction

    // Hold the request until accepted, then maybe idle between bursts.
    task automatic send_request(input echo_request_t r);
        int gap;
        s_valid              <= 1'b1;
        s_voice              <= r.voice;
        s_left_sample        <= r.left_in;
        s_right_sample       <= r.right_in;
        s_right_connected    <= r.right_connected;
        s_delay_left_offset  <= r.delay_left_ofs;
        s_delay_right_offset <= r.delay_right_ofs;
        s_feedback_offset    <= r.feedback_ofs;
        s_mix_offset         <= r.mix_ofs;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (!quiet_sender) begin
                gap = $urandom_range(0, 7);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic finish_phase();
        s_valid <= 1'b0;
        // let the last accepted request reach the scoreboard first
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all four registers plus one unused index.
    task automatic apply_setting(input logic [15:0] dl, input logic [15:0] dr,
                                 input logic [15:0] fb, input logic [15:0] mx,
                                 input logic [CFG_INDEX_W-1:0] stray_idx);
        write_register(CFG_DELAY_LEFT, dl);
        write_register(CFG_DELAY_RIGHT, dr);
        write_register(CFG_FEEDBACK, fb);
        write_register(CFG_MIX, mx);
        write_register(stray_idx, 16'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: offset extremes clamp delay, feedback and mix
        send_request(make_request(0, PEAK_POS, PEAK_NEG, 1, 0, 0, 0, 0));
        send_request(make_request(0, PEAK_POS, PEAK_NEG, 1, OFS_MIN, OFS_MIN, OFS_MAX, OFS_MAX));
        send_request(make_request(0, PEAK_NEG, PEAK_POS, 0, OFS_MIN, OFS_MIN, OFS_MAX, OFS_MIN));
        send_request(make_request(0, PEAK_POS, PEAK_POS, 1, OFS_MIN, OFS_MIN, OFS_MAX, 0));
        send_request(make_request(0, PEAK_NEG, PEAK_NEG, 1, OFS_MIN, OFS_MIN, OFS_MAX, 0));
        send_request(make_request(0, 0, 0, 1, OFS_MAX, OFS_MAX, OFS_MIN, 0));
        // half-way values round up
        send_request(make_request(TOP_VOICE, -1, 1, 0, 0, 0, 0, 0));
        send_request(make_request(TOP_VOICE, 1, -1, 1, -16'sd11999, -16'sd11998, 0, 0));
        finish_phase();

        // Zero delays clamp to one sample; oversized feedback is masked then clamped, oversized mix is clamped
        apply_setting(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, CFG_INDEX_TOP);
        send_request(make_request(3, PEAK_POS, 24'sd12345, 1, 0, 0, 0, 0));
        send_request(make_request(3, 24'sd100, -24'sd100, 1, 0, 0, 0, 0));
        send_request(make_request(3, PEAK_NEG, PEAK_POS, 0, 0, 0, OFS_MIN, OFS_MIN));
        send_request(make_request(3, PEAK_NEG, PEAK_NEG, 1, 0, 0, 0, 0));
        finish_phase();

        // Longest base delays, no base feedback, dry-only base mix
        apply_setting(16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000,
                      CFG_INDEX_W'($urandom_range(int'(CFG_MIX) + 1, int'(CFG_INDEX_TOP))));
        send_request(make_request(3, PEAK_POS, PEAK_NEG, 1, 0, 0, 0, 0));
        send_request(make_request(3, PEAK_NEG, PEAK_POS, 1, OFS_MAX, OFS_MAX, OFS_MAX, OFS_MAX));
        send_request(make_request(3, 24'sd7, -24'sd7, 1, -16'sd32766, -16'sd32765, OFS_MAX,
                                  16'sd16384));
        finish_phase();

        // Random traffic over mostly short delays so feedback builds up in every voice
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet_sender = (p == 3);
            apply_setting(16'($urandom_range(0, 40)),
                          (p == 5) ? 16'($urandom_range(1000, 32767)) : 16'($urandom_range(0, 40)),
                          16'($urandom()),
                          16'($urandom_range(0, 40000)),
                          CFG_INDEX_W'($urandom_range(int'(CFG_MIX) + 1, int'(CFG_INDEX_TOP))));
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                send_request(random_request());
                // hold off once mid-phase until the pipeline is empty
                if (p == 2 && n == PHASE_REQUESTS / 2) finish_phase();
            end
            finish_phase();
        end

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("** stereo_feedback_delay: PASSED **");
        end else begin
            $display("** stereo_feedback_delay: FAILED **");
        end
        $finish;
    end

    // Bound the run time
    initial begin
        #4_000_000;
        $display("** stereo_feedback_delay: FAILED **");
        $finish;
    end

endmodule

// ===== stereo_feedback_delay.f =====
+incdir+hdl
hdl/sfd_pkg.sv
hdl/stereo_feedback_delay.sv
tb/stereo_feedback_delay_tb.sv
